// File: hdl/assert_macros.svh
// assertion macros shared by the frame parser rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/imu_fp_pkg.sv
// shared constants, result type and scaling function of the imu frame parser
// no dependencies
`default_nettype none

package imu_fp_pkg;

	localparam logic [7:0] HdrByte   = 8'h55;
	localparam logic [7:0] TypeRate  = 8'h52;
	localparam logic [7:0] TypeAngle = 8'h53;

	// byte positions inside the 11-byte frame
	localparam logic [3:0] TypePos     = 4'd1;
	localparam logic [3:0] DataFirst   = 4'd2;
	localparam logic [3:0] DataLast    = 4'd7;
	localparam logic [3:0] ChecksumPos = 4'd10;
	localparam int         DataBytes   = 6;

	// fixed point scale: rate raw*125>>7, angle raw*45>>6
	localparam logic signed [23:0] RateMul  = 24'sd125;
	localparam logic signed [23:0] AngleMul = 24'sd45;

	typedef struct packed {
		logic               hit;
		logic               kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} fp_result_t;

	// floor scaling of a little-endian signed 16-bit value
	function automatic logic signed [15:0] scale_value(input logic [7:0] lo,
			input logic [7:0] hi, input logic kind);
		logic signed [15:0] raw;
		logic signed [23:0] ext;
		logic signed [23:0] prod;
		raw  = {hi, lo};
		ext  = 24'(raw);
		prod = ext * (kind ? AngleMul : RateMul);
		return kind ? prod[21:6] : prod[22:7];
	endfunction

endpackage

`default_nettype wire

// File: hdl/imu_fp_core.sv
// frame state of the imu frame parser: byte position, running checksum,
// stored type and data bytes, and the decode of a finished frame
// depends on imu_fp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module imu_fp_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             rx_byte,
	output imu_fp_pkg::fp_result_t      res
);
	import imu_fp_pkg::*;

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] type_q;
	logic [7:0] data_q [DataBytes];

	logic       drop;
	logic       at_check;
	logic [2:0] data_off;
	logic       good_type;

	assign drop      = (pos_q == 4'd0) && (rx_byte != HdrByte);
	assign at_check  = (pos_q == ChecksumPos);
	assign data_off  = 3'(pos_q - DataFirst);
	assign good_type = (type_q == TypeRate) || (type_q == TypeAngle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			if (at_check) begin
				pos_q <= '0;
				sum_q <= '0;
			end else if (!drop) begin
				pos_q <= pos_q + 4'd1;
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && pos_q == TypePos) begin
			type_q <= rx_byte;
		end
		if (step && pos_q >= DataFirst && pos_q <= DataLast) begin
			data_q[data_off] <= rx_byte;
		end
	end

	always_comb begin
		res.hit  = step && at_check && (sum_q == rx_byte) && good_type;
		// 0x52 and 0x53 differ only in bit 0
		res.kind = type_q[0];
		res.x    = scale_value(data_q[0], data_q[1], type_q[0]);
		res.y    = scale_value(data_q[2], data_q[3], type_q[0]);
		res.z    = scale_value(data_q[4], data_q[5], type_q[0]);
	end

	`ASSERT_IMPLIES(a_pos_range, 1'b1, pos_q <= ChecksumPos)
	`ASSERT_IMPLIES(a_hit_at_check, res.hit, step && pos_q == ChecksumPos)
	`ASSERT_NEXT(a_back_to_idle, step && at_check, pos_q == 4'd0 && sum_q == 8'd0)

endmodule

`default_nettype wire

// File: hdl/imu_frame_parser.sv
// imu frame parser
// -----------------------------------------------------------------------
// input channel (in_valid/in_ready): one received serial byte rx_byte with
// the current millisecond time now_ms per transfer. bytes before a 0x55
// header are dropped; an 11-byte frame is then collected with a running
// 8-bit checksum over bytes 0..9 compared against byte 10.
// output channel (out_valid/out_ready): one transfer per good frame of type
// 0x52 (angular rate, frame_kind 0, 1/16 deg/s) or 0x53 (angle, frame_kind
// 1, 1/128 deg), carrying x/y/z scaled values and the stamp_ms of the
// checksum byte. bad checksums and other types give nothing.
// order: an accepted checksum byte lands in the input register, and its result
// moves into the result register once that register is empty or being taken.
// throughput: one byte per cycle unless a held result stalls; the frame
// state update and scaling sit between the input and result registers.
// reset: position and checksum clear to waiting for a header, both
// pipeline registers empty. when the receiver stalls, the result register
// holds and the input register fills; in_ready drops only when both hold.
// -----------------------------------------------------------------------
// depends on imu_fp_pkg, imu_fp_core and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module imu_frame_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [31:0]        now_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    frame_kind,
	output logic signed [15:0]      x_value,
	output logic signed [15:0]      y_value,
	output logic signed [15:0]      z_value,
	output logic [31:0]             stamp_ms
);
	import imu_fp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] now_s1;
	logic        valid_s2;
	logic        advance;
	logic        step;
	fp_result_t  res;

	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= res.hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			now_s1  <= now_ms;
		end
		if (advance && res.hit) begin
			frame_kind <= res.kind;
			x_value    <= res.x;
			y_value    <= res.y;
			z_value    <= res.z;
			stamp_ms   <= now_s1;
		end
	end

	imu_fp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	assign out_valid = valid_s2;

	// a byte waiting behind a stalled result must not be lost
	`ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1 && $stable(byte_s1))

endmodule

`default_nettype wire
